/* hw/rtl/cpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpe_pkg
// shared widths, codes and controller/datapath types for the closest point
// on polygon edge block
// ----------------------------------------------------------------------------
package cpe_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam int COORD_W = 24;   // Q16.8 coordinate
    localparam int IDX_W   = 6;    // vertex index field
    localparam int CNT_W   = 7;    // vertex_count register
    localparam int RAD_W   = 16;   // handle_radius register
    localparam int CFG_W   = 16;   // widest register
    localparam int CFG_IDX_W = 1;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MOP_W   = 26;   // multiplier operand
    localparam int PROD_W  = 2 * MOP_W;
    localparam int ACC_W   = PROD_W;
    localparam int FRAC_W  = 16;   // fraction bits of t
    localparam int STEP_W  = 4;    // counts FRAC_W division steps
    localparam int LIM_OFS = 512;  // 2.0 in Q8.8

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HANDLE_RADIUS = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE, S_RD_A, S_RD_B, S_DIFF,
        S_L0, S_L1, S_L2, S_L3, S_D1, S_D2,
        S_CLS, S_DIV, S_T0, S_T1, S_T2,
        S_QD, S_Q1, S_Q2, S_Q3, S_Q4,
        S_K0, S_K1, S_K2, S_K3,
        S_VR, S_VW, S_V1, S_V2, S_V3, S_V4,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        MUL_SXSX, MUL_SYSY, MUL_UXSX, MUL_UYSY, MUL_TSX, MUL_TSY,
        MUL_DXDX, MUL_DYDY, MUL_LIM, MUL_R2
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD
    } t_acc_op;

    typedef enum logic [4:0] {
        DP_NOP, DP_WRITE, DP_LOAD_Q, DP_CAP_A, DP_EDGE_DIFF, DP_SAVE_LEN,
        DP_SAVE_DOT, DP_CLAMP_A, DP_CLAMP_B, DP_DIV_START, DP_DIV_STEP,
        DP_PROJ_X, DP_PROJ_Y, DP_Q_DIFF, DP_BEST_UPD, DP_SAVE_LIM,
        DP_SAVE_R2, DP_V_DIFF, DP_EMIT_FOUND, DP_EMIT_MISS
    } t_dp_op;

    typedef struct packed {
        t_dp_op   dp_op;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     first;
    } t_dp_cmd;

    typedef struct packed {
        logic len_zero;
        logic dot_neg;
        logic dot_ge_len;
        logic best_lt_lim;
        logic acc_lt_r2;
    } t_dp_status;

endpackage

/* hw/rtl/cpe_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpe_in_if
// input channel: vertex writes and queries
// ----------------------------------------------------------------------------
interface cpe_in_if
    import cpe_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [IDX_W-1:0]           vertex_index;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;

    modport source (output valid, op, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, op, vertex_index, coord_x, coord_y, output ready);
endinterface

/* hw/rtl/cpe_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpe_out_if
// result channel: closest boundary point of a query
// ----------------------------------------------------------------------------
interface cpe_out_if
    import cpe_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic [IDX_W-1:0]           edge_start;
    logic [IDX_W-1:0]           edge_end;

    modport source (output valid, found, point_x, point_y, edge_start, edge_end,
                    input ready);
    modport sink   (input valid, found, point_x, point_y, edge_start, edge_end,
                    output ready);
endinterface

/* hw/rtl/cpe_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpe_dp
// datapath: vertex memory, shared multiplier and accumulator, serial divider,
// best edge tracking and result register
// ----------------------------------------------------------------------------
module cpe_dp
    import cpe_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int AW = $clog2(MAX_VERTICES)
) (
    input  logic                       i_clk,
    input  t_dp_cmd                    i_cmd,
    input  logic [AW-1:0]              i_mem_addr,
    input  logic [AW-1:0]              i_edge_start,
    input  logic [AW-1:0]              i_edge_end,
    input  logic signed [COORD_W-1:0]  i_coord_x,
    input  logic signed [COORD_W-1:0]  i_coord_y,
    input  logic [RAD_W-1:0]           i_handle_radius,
    output t_dp_status                 o_status,
    output logic                       o_found,
    output logic signed [COORD_W-1:0]  o_point_x,
    output logic signed [COORD_W-1:0]  o_point_y,
    output logic [IDX_W-1:0]           o_edge_start,
    output logic [IDX_W-1:0]           o_edge_end
);

    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_W - 1);

    logic [2*COORD_W-1:0] mem [MAX_VERTICES];
    logic [2*COORD_W-1:0] r_rdata;

    logic signed [COORD_W-1:0] r_px, r_py, r_ax, r_ay, r_bx, r_by, r_qx, r_qy;
    logic signed [COORD_W-1:0] r_best_x, r_best_y;
    logic [AW-1:0]             r_best_i, r_best_j;
    logic signed [DIFF_W-1:0]  r_sx, r_sy, r_ux, r_uy, r_dx, r_dy;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc, r_len, r_dot, r_best, r_lim2, r_r2;
    logic [ACC_W-1:0]          r_rem;
    logic [FRAC_W-1:0]         r_t;

    logic                       r_found;
    logic signed [COORD_W-1:0]  r_out_x, r_out_y;
    logic [IDX_W-1:0]           r_out_s, r_out_e;

    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic signed [MOP_W-1:0]   m_a, m_b;
    logic [RAD_W:0]            lim, rad2;
    logic [ACC_W-1:0]          rem_sh;
    logic signed [PROD_W-1:0]  rnd;

    assign rd_x   = signed'(r_rdata[2*COORD_W-1:COORD_W]);
    assign rd_y   = signed'(r_rdata[COORD_W-1:0]);
    assign lim    = {1'b0, i_handle_radius} + (RAD_W+1)'(LIM_OFS);
    assign rad2   = {i_handle_radius, 1'b0};
    assign rem_sh = {r_rem[ACC_W-2:0], 1'b0};
    assign rnd    = (r_prod + HALF) >>> FRAC_W;

    always_ff @(posedge i_clk) begin
        if (i_cmd.dp_op == DP_WRITE) begin
            mem[i_mem_addr] <= {i_coord_x, i_coord_y};
        end
        r_rdata <= mem[i_mem_addr];
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_SXSX: begin m_a = MOP_W'(r_sx); m_b = MOP_W'(r_sx); end
            MUL_SYSY: begin m_a = MOP_W'(r_sy); m_b = MOP_W'(r_sy); end
            MUL_UXSX: begin m_a = MOP_W'(r_ux); m_b = MOP_W'(r_sx); end
            MUL_UYSY: begin m_a = MOP_W'(r_uy); m_b = MOP_W'(r_sy); end
            MUL_TSX:  begin m_a = MOP_W'(signed'({1'b0, r_t})); m_b = MOP_W'(r_sx); end
            MUL_TSY:  begin m_a = MOP_W'(signed'({1'b0, r_t})); m_b = MOP_W'(r_sy); end
            MUL_DXDX: begin m_a = MOP_W'(r_dx); m_b = MOP_W'(r_dx); end
            MUL_DYDY: begin m_a = MOP_W'(r_dy); m_b = MOP_W'(r_dy); end
            MUL_LIM:  begin
                m_a = MOP_W'(signed'({1'b0, lim}));
                m_b = MOP_W'(signed'({1'b0, lim}));
            end
            MUL_R2:   begin
                m_a = MOP_W'(signed'({1'b0, rad2}));
                m_b = MOP_W'(signed'({1'b0, rad2}));
            end
            default:  begin m_a = '0; m_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        unique case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            default:  r_acc <= r_acc;
        endcase

        unique case (i_cmd.dp_op)
            DP_LOAD_Q: begin
                r_px <= i_coord_x;
                r_py <= i_coord_y;
            end
            DP_CAP_A: begin
                r_ax <= rd_x;
                r_ay <= rd_y;
            end
            DP_EDGE_DIFF: begin
                r_bx <= rd_x;
                r_by <= rd_y;
                r_sx <= DIFF_W'(rd_x) - DIFF_W'(r_ax);
                r_sy <= DIFF_W'(rd_y) - DIFF_W'(r_ay);
                r_ux <= DIFF_W'(r_px) - DIFF_W'(r_ax);
                r_uy <= DIFF_W'(r_py) - DIFF_W'(r_ay);
            end
            DP_SAVE_LEN: r_len <= r_acc;
            DP_SAVE_DOT: r_dot <= r_acc;
            DP_CLAMP_A: begin
                r_qx <= r_ax;
                r_qy <= r_ay;
            end
            DP_CLAMP_B: begin
                r_qx <= r_bx;
                r_qy <= r_by;
            end
            DP_DIV_START: begin
                r_rem <= unsigned'(r_dot);
                r_t   <= '0;
            end
            DP_DIV_STEP: begin
                // one quotient bit per step, remainder stays below the length
                if (rem_sh >= unsigned'(r_len)) begin
                    r_rem <= rem_sh - unsigned'(r_len);
                    r_t   <= {r_t[FRAC_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_t   <= {r_t[FRAC_W-2:0], 1'b0};
                end
            end
            DP_PROJ_X: r_qx <= r_ax + COORD_W'(rnd);
            DP_PROJ_Y: r_qy <= r_ay + COORD_W'(rnd);
            DP_Q_DIFF: begin
                r_dx <= DIFF_W'(r_qx) - DIFF_W'(r_px);
                r_dy <= DIFF_W'(r_qy) - DIFF_W'(r_py);
            end
            DP_BEST_UPD: begin
                if (i_cmd.first || r_acc < r_best) begin
                    r_best   <= r_acc;
                    r_best_x <= r_qx;
                    r_best_y <= r_qy;
                    r_best_i <= i_edge_start;
                    r_best_j <= i_edge_end;
                end
            end
            DP_SAVE_LIM: r_lim2 <= r_prod;
            DP_SAVE_R2:  r_r2   <= r_prod;
            DP_V_DIFF: begin
                r_dx <= DIFF_W'(rd_x) - DIFF_W'(r_best_x);
                r_dy <= DIFF_W'(rd_y) - DIFF_W'(r_best_y);
            end
            DP_EMIT_FOUND: begin
                r_found <= 1'b1;
                r_out_x <= r_best_x;
                r_out_y <= r_best_y;
                r_out_s <= IDX_W'(r_best_i);
                r_out_e <= IDX_W'(r_best_j);
            end
            DP_EMIT_MISS: begin
                r_found <= 1'b0;
                r_out_x <= '0;
                r_out_y <= '0;
                r_out_s <= '0;
                r_out_e <= '0;
            end
            default: ;
        endcase
    end

    assign o_status.len_zero    = (r_len == '0);
    assign o_status.dot_neg     = (r_dot < 0);
    assign o_status.dot_ge_len  = (r_dot >= r_len);
    assign o_status.best_lt_lim = (r_best < r_lim2);
    assign o_status.acc_lt_r2   = (r_acc < r_r2);

    assign o_found      = r_found;
    assign o_point_x    = r_out_x;
    assign o_point_y    = r_out_y;
    assign o_edge_start = r_out_s;
    assign o_edge_end   = r_out_e;

endmodule

/* hw/rtl/cpe_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpe_ctrl
// sequencer: walks the edges, then the vertex clearance check, and owns the
// input and output handshakes
// ----------------------------------------------------------------------------
module cpe_ctrl
    import cpe_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int AW = $clog2(MAX_VERTICES),
    localparam int CW = $clog2(MAX_VERTICES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  logic [IDX_W-1:0]  i_vertex_index,
    input  logic [CNT_W-1:0]  i_vertex_count,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  t_dp_status        i_status,
    output t_dp_cmd           o_cmd,
    output logic [AW-1:0]     o_mem_addr,
    output logic [AW-1:0]     o_edge_start,
    output logic [AW-1:0]     o_edge_end
);

    localparam int NCW = (CNT_W > CW) ? CNT_W : CW;
    localparam int IXW = (IDX_W > CW) ? IDX_W : CW;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAC_W - 1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_n, n_n;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_hit, n_hit;
    logic               r_out_valid, n_out_valid;

    logic [NCW-1:0]     cnt_ext;
    logic [CW-1:0]      cnt_sel;
    logic               is_last;
    logic [AW-1:0]      j;

    assign cnt_ext = NCW'(i_vertex_count);
    assign cnt_sel = (cnt_ext > NCW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(cnt_ext);
    assign is_last = (CW'(r_i) == r_n - CW'(1));
    assign j       = is_last ? '0 : r_i + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_n         <= '0;
            r_step      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_n         <= n_n;
            r_step      <= n_step;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_i          = r_i;
        n_n          = r_n;
        n_step       = r_step;
        n_hit        = r_hit;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_in_ready   = 1'b0;
        o_cmd.dp_op  = DP_NOP;
        o_cmd.mul_sel = MUL_SXSX;
        o_cmd.acc_op = ACC_HOLD;
        o_cmd.first  = (r_i == '0);
        o_mem_addr   = r_i;

        unique case (r_state)
            S_IDLE: begin
                // no beat is taken while reset is held
                o_in_ready = i_rst_n;
                o_mem_addr = AW'(i_vertex_index);
                if (i_in_valid && i_rst_n) begin
                    if (i_op == OP_WRITE) begin
                        if (IXW'(i_vertex_index) < IXW'(MAX_VERTICES)) begin
                            o_cmd.dp_op = DP_WRITE;
                        end
                    end else begin
                        o_cmd.dp_op = DP_LOAD_Q;
                        n_n = cnt_sel;
                        n_i = '0;
                        n_hit = 1'b0;
                        n_state = (cnt_sel < CW'(2)) ? S_EMIT : S_RD_A;
                    end
                end
            end
            S_RD_A: n_state = S_RD_B;
            S_RD_B: begin
                o_mem_addr  = j;
                o_cmd.dp_op = DP_CAP_A;
                n_state     = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.dp_op = DP_EDGE_DIFF;
                n_state     = S_L0;
            end
            // squared length and dot product share the multiplier back to back
            S_L0: begin
                o_cmd.mul_sel = MUL_SXSX;
                n_state = S_L1;
            end
            S_L1: begin
                o_cmd.mul_sel = MUL_SYSY;
                o_cmd.acc_op  = ACC_LOAD;
                n_state = S_L2;
            end
            S_L2: begin
                o_cmd.mul_sel = MUL_UXSX;
                o_cmd.acc_op  = ACC_ADD;
                n_state = S_L3;
            end
            S_L3: begin
                o_cmd.dp_op   = DP_SAVE_LEN;
                o_cmd.mul_sel = MUL_UYSY;
                o_cmd.acc_op  = ACC_LOAD;
                n_state = S_D1;
            end
            S_D1: begin
                o_cmd.acc_op = ACC_ADD;
                n_state = S_D2;
            end
            S_D2: begin
                o_cmd.dp_op = DP_SAVE_DOT;
                n_state = S_CLS;
            end
            S_CLS: begin
                priority if (i_status.len_zero || i_status.dot_neg) begin
                    o_cmd.dp_op = DP_CLAMP_A;
                    n_state = S_QD;
                end else if (i_status.dot_ge_len) begin
                    o_cmd.dp_op = DP_CLAMP_B;
                    n_state = S_QD;
                end else begin
                    o_cmd.dp_op = DP_DIV_START;
                    n_step = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.dp_op = DP_DIV_STEP;
                n_step = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_T0;
                end
            end
            S_T0: begin
                o_cmd.mul_sel = MUL_TSX;
                n_state = S_T1;
            end
            S_T1: begin
                o_cmd.mul_sel = MUL_TSY;
                o_cmd.dp_op   = DP_PROJ_X;
                n_state = S_T2;
            end
            S_T2: begin
                o_cmd.dp_op = DP_PROJ_Y;
                n_state = S_QD;
            end
            S_QD: begin
                o_cmd.dp_op = DP_Q_DIFF;
                n_state = S_Q1;
            end
            S_Q1: begin
                o_cmd.mul_sel = MUL_DXDX;
                n_state = S_Q2;
            end
            S_Q2: begin
                o_cmd.mul_sel = MUL_DYDY;
                o_cmd.acc_op  = ACC_LOAD;
                n_state = S_Q3;
            end
            S_Q3: begin
                o_cmd.acc_op = ACC_ADD;
                n_state = S_Q4;
            end
            S_Q4: begin
                o_cmd.dp_op = DP_BEST_UPD;
                if (is_last) begin
                    n_state = S_K0;
                end else begin
                    n_i = r_i + AW'(1);
                    n_state = S_RD_A;
                end
            end
            S_K0: begin
                o_cmd.mul_sel = MUL_LIM;
                n_state = S_K1;
            end
            S_K1: begin
                o_cmd.mul_sel = MUL_R2;
                o_cmd.dp_op   = DP_SAVE_LIM;
                n_state = S_K2;
            end
            S_K2: begin
                o_cmd.dp_op = DP_SAVE_R2;
                n_state = S_K3;
            end
            S_K3: begin
                n_i = '0;
                n_state = i_status.best_lt_lim ? S_VR : S_EMIT;
            end
            // clearance of the chosen point from every vertex
            S_VR: n_state = S_VW;
            S_VW: begin
                o_cmd.dp_op = DP_V_DIFF;
                n_state = S_V1;
            end
            S_V1: begin
                o_cmd.mul_sel = MUL_DXDX;
                n_state = S_V2;
            end
            S_V2: begin
                o_cmd.mul_sel = MUL_DYDY;
                o_cmd.acc_op  = ACC_LOAD;
                n_state = S_V3;
            end
            S_V3: begin
                o_cmd.acc_op = ACC_ADD;
                n_state = S_V4;
            end
            S_V4: begin
                priority if (i_status.acc_lt_r2) begin
                    n_state = S_EMIT;
                end else if (is_last) begin
                    n_hit = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_i = r_i + AW'(1);
                    n_state = S_VR;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.dp_op = r_hit ? DP_EMIT_FOUND : DP_EMIT_MISS;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_edge_start = r_i;
    assign o_edge_end   = j;

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result beat raised outside emit");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_EMIT) |-> CW'(r_i) < r_n)
        else $error("vertex index beyond vertex count");

    a_edge_walk_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD_A |-> r_n >= CW'(2))
        else $error("edge walk with fewer than two vertices");

    a_div_starts_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && $past(r_state) != S_DIV) |-> r_step == '0)
        else $error("divider entered with stale step count");

endmodule

/* hw/rtl/closest_point_on_polygon_edge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_on_polygon_edge
// nearest point on the closed boundary of a stored polygon, for handle placement
// ----------------------------------------------------------------------------
// usage
//   i_item carries beats of two kinds: a write stores a vertex in slot
//   vertex_index and gives no result; a query gives exactly one o_result beat.
//   vertex_count and handle_radius are written through i_cfg_*; the user must
//   do so only while idle, as the block does not enforce it. a query walks
//   every edge on one shared multiplier and a one bit per cycle divider, used
//   when the projection falls inside the segment, then fetches the limits,
//   checks clearance from each vertex if the best point is near enough, and
//   issues the result, at once when fewer than two vertices are used.
//   one query is in flight at a time; i_item.ready is high only between items.
//   the result sits in an output register, so new beats are taken while it
//   waits; a second query finishing before the first is taken holds there.
//   reset (i_rst_n low, synchronous) clears both registers and the control;
//   vertex slots hold nothing defined until written.
// ----------------------------------------------------------------------------
module closest_point_on_polygon_edge
    import cpe_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cpe_in_if.sink                i_item,
    cpe_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);

    logic [CNT_W-1:0] r_vertex_count;
    logic [RAD_W-1:0] r_handle_radius;

    t_dp_cmd          cmd;
    t_dp_status       status;
    logic [AW-1:0]    mem_addr, edge_start, edge_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count  <= '0;
            r_handle_radius <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VERTEX_COUNT:  r_vertex_count  <= i_cfg_data[CNT_W-1:0];
                REG_HANDLE_RADIUS: r_handle_radius <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    cpe_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_item.valid),
        .o_in_ready     (i_item.ready),
        .i_op           (i_item.op),
        .i_vertex_index (i_item.vertex_index),
        .i_vertex_count (r_vertex_count),
        .o_out_valid    (o_result.valid),
        .i_out_ready    (o_result.ready),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_mem_addr     (mem_addr),
        .o_edge_start   (edge_start),
        .o_edge_end     (edge_end)
    );

    cpe_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .i_mem_addr      (mem_addr),
        .i_edge_start    (edge_start),
        .i_edge_end      (edge_end),
        .i_coord_x       (i_item.coord_x),
        .i_coord_y       (i_item.coord_y),
        .i_handle_radius (r_handle_radius),
        .o_status        (status),
        .o_found         (o_result.found),
        .o_point_x       (o_result.point_x),
        .o_point_y       (o_result.point_y),
        .o_edge_start    (o_result.edge_start),
        .o_edge_end      (o_result.edge_end)
    );

endmodule

/* bench/cpe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpe_checker
// watches the item, result and register ports of the closest point block,
// keeps its own vertex memory and registers, predicts each query answer and
// compares every result beat field by field in order
// ----------------------------------------------------------------------------
module cpe_checker
    import cpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cpe_in_if                     item_ch,
    cpe_out_if                    result_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count,
    output int                    o_result_count,
    output int                    o_found_count
);

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [IDX_W-1:0]   e_start;
        logic [IDX_W-1:0]   e_end;
    } t_answer;

    longint          vx [MAX_VERTICES_DEF];
    longint          vy [MAX_VERTICES_DEF];
    logic [CNT_W-1:0] vcount;
    logic [RAD_W-1:0] radius;
    t_answer         answers_due[$];
    int              fails, results, founds;

    assign o_pending      = answers_due.size();
    assign o_fail_count   = fails;
    assign o_result_count = results;
    assign o_found_count  = founds;

    function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
        return (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
    endfunction

    // divide by 65536, nearest, ties toward plus infinity
    function automatic longint round_t(longint v);
        longint w;
        w = v + 32768;
        if (w >= 0) return w >>> 16;
        return -((-w + 65535) >>> 16);
    endfunction

    function automatic longint t_fraction(longint num, longint den);
        longint rem, q;
        rem = num;
        q = 0;
        if (rem >= den) return 65536;
        for (int k = 0; k < FRAC_W; k++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint nearest_on_edge(longint ax, longint ay, longint bx,
                                               longint by, longint px, longint py,
                                               output longint qx, output longint qy);
        longint sx, sy, len2, dot, t;
        sx = bx - ax;
        sy = by - ay;
        len2 = sx * sx + sy * sy;
        dot = (px - ax) * sx + (py - ay) * sy;
        if (len2 == 0 || dot < 0) begin
            qx = ax; qy = ay;
        end else if (dot > len2) begin
            qx = bx; qy = by;
        end else begin
            t = t_fraction(dot, len2);
            qx = ax + round_t(t * sx);
            qy = ay + round_t(t * sy);
        end
        return sq_dist(qx, qy, px, py);
    endfunction

    function automatic t_answer closest_boundary_point(longint px, longint py);
        t_answer a;
        int n, j, bi, bj;
        longint d, best, bx, by, qx, qy, lim, r2;
        logic ok;
        a = '0;
        n = (vcount > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(vcount);
        if (n < 2) return a;
        best = 0; bx = 0; by = 0; bi = 0; bj = 0;
        for (int i = 0; i < n; i++) begin
            j = (i + 1 == n) ? 0 : i + 1;
            d = nearest_on_edge(vx[i], vy[i], vx[j], vy[j], px, py, qx, qy);
            if (i == 0 || d < best) begin
                best = d; bx = qx; by = qy; bi = i; bj = j;
            end
        end
        lim = longint'(radius) + LIM_OFS;
        if (best >= lim * lim) return a;
        r2 = 2 * longint'(radius);
        r2 = r2 * r2;
        ok = 1'b1;
        for (int i = 0; i < n; i++)
            if (sq_dist(vx[i], vy[i], bx, by) < r2) ok = 1'b0;
        if (!ok) return a;
        a.found = 1'b1;
        a.px = bx[COORD_W-1:0];
        a.py = by[COORD_W-1:0];
        a.e_start = bi[IDX_W-1:0];
        a.e_end = bj[IDX_W-1:0];
        return a;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        fails++;
    endtask

    initial begin
        fails = 0; results = 0; founds = 0;
        vcount = '0; radius = '0;
        for (int i = 0; i < MAX_VERTICES_DEF; i++) begin
            vx[i] = 0; vy[i] = 0;
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            vcount <= '0;
            radius <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_VERTEX_COUNT) vcount <= i_cfg_data[CNT_W-1:0];
                else if (i_cfg_idx == REG_HANDLE_RADIUS) radius <= i_cfg_data[RAD_W-1:0];
            end
            // result beat first: it always belongs to an earlier query
            if (result_ch.valid && result_ch.ready) begin
                results++;
                if (answers_due.size() == 0) begin
                    report("unexpected result beat", 1, 0);
                end else begin
                    want = answers_due.pop_front();
                    if (result_ch.found) founds++;
                    if (result_ch.found !== want.found)
                        report("found", result_ch.found, want.found);
                    if (result_ch.point_x !== want.px)
                        report("point_x", result_ch.point_x, want.px);
                    if (result_ch.point_y !== want.py)
                        report("point_y", result_ch.point_y, want.py);
                    if (result_ch.edge_start !== want.e_start)
                        report("edge_start", result_ch.edge_start, want.e_start);
                    if (result_ch.edge_end !== want.e_end)
                        report("edge_end", result_ch.edge_end, want.e_end);
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                if (item_ch.op == OP_WRITE) begin
                    vx[item_ch.vertex_index] = longint'(item_ch.coord_x);
                    vy[item_ch.vertex_index] = longint'(item_ch.coord_y);
                end else begin
                    answers_due.push_back(closest_boundary_point(
                        longint'(item_ch.coord_x), longint'(item_ch.coord_y)));
                end
            end
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives vertex writes, queries and register settings into the closest point
// block under random sender gaps and receiver stalls; the checker predicts
// and compares every result
// ----------------------------------------------------------------------------
module tb_top;
    import cpe_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    cpe_in_if  item_ch ();
    cpe_out_if result_ch ();

    int pending, fail_count, result_count, found_count;
    int gap_pct, stall_pct, cycles, queries;
    logic hold_off, pressure_go;

    longint px_copy [MAX_VERTICES_DEF];
    longint py_copy [MAX_VERTICES_DEF];
    int     cur_count, cur_radius;

    closest_point_on_polygon_edge dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    cpe_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .item_ch        (item_ch),
        .result_ch      (result_ch),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_result_count (result_count),
        .o_found_count  (found_count)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending);
            $display("tb_top failed");
            $finish;
        end
    end

    // receiver side
    always @(posedge i_clk) begin
        if (hold_off) result_ch.ready <= 1'b0;
        else result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (4000) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // valid is left high after a beat; the next beat replaces it, a gap or an idle lowers it
    task automatic send(input logic op, input int idx, input longint x, input longint y);
        while ($urandom_range(99) < gap_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.op           <= op;
        item_ch.vertex_index <= idx[IDX_W-1:0];
        item_ch.coord_x      <= x[COORD_W-1:0];
        item_ch.coord_y      <= y[COORD_W-1:0];
        if (op == OP_QUERY) queries++;
        else begin
            px_copy[idx] = longint'(signed'(x[COORD_W-1:0]));
            py_copy[idx] = longint'(signed'(y[COORD_W-1:0]));
        end
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic configure(input int count, input int rad);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_VERTEX_COUNT;
        i_cfg_data <= CFG_W'(count);
        @(posedge i_clk);
        i_cfg_idx  <= REG_HANDLE_RADIUS;
        i_cfg_data <= CFG_W'(rad);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_count  = (count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : count;
        cur_radius = rad;
    endtask

    task automatic write_polygon(input int n, input int span);
        for (int i = 0; i < n; i++)
            send(OP_WRITE, i, $urandom_range(2 * span) - span,
                 $urandom_range(2 * span) - span);
    endtask

    // point near a random edge of the current polygon, within reach of found
    task automatic query_near_edge();
        int i, j, f, reach;
        longint x, y;
        i = $urandom_range(cur_count - 1);
        j = (i + 1 == cur_count) ? 0 : i + 1;
        f = $urandom_range(256);
        reach = (cur_radius > 4000 ? 4000 : cur_radius) + 600;
        x = px_copy[i] + (px_copy[j] - px_copy[i]) * f / 256
            + int'($urandom_range(2 * reach)) - reach;
        y = py_copy[i] + (py_copy[j] - py_copy[i]) * f / 256
            + int'($urandom_range(2 * reach)) - reach;
        send(OP_QUERY, 0, x, y);
    endtask

    initial begin
        int count, rad, sel;
        cycles = 0; queries = 0;
        gap_pct = 10; stall_pct = 46;
        hold_off = 1'b0; pressure_go = 1'b0;
        cur_count = 0; cur_radius = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        item_ch.valid = 1'b0; item_ch.op = OP_WRITE; item_ch.vertex_index = '0;
        item_ch.coord_x = '0; item_ch.coord_y = '0;
        result_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every slot gets a value before any query can read it
        write_polygon(MAX_VERTICES_DEF, 40000);

        // fewer than two vertices
        configure(0, 256);
        send(OP_QUERY, 0, 0, 0);
        configure(1, 256);
        send(OP_QUERY, 0, 100, 100);
        // degenerate edge
        send(OP_WRITE, 0, 1000, 1000);
        send(OP_WRITE, 1, 1000, 1000);
        configure(2, 100);
        send(OP_QUERY, 0, 1200, 1000);
        // square: inside an edge, equal distances, clamping past both ends, near a corner
        send(OP_WRITE, 0, 0, 0);
        send(OP_WRITE, 1, 25600, 0);
        send(OP_WRITE, 2, 25600, 25600);
        send(OP_WRITE, 3, 0, 25600);
        configure(4, 256);
        send(OP_QUERY, 0, 12800, 100);
        send(OP_QUERY, 0, 12800, 12800);
        send(OP_QUERY, 0, -500, -500);
        send(OP_QUERY, 0, 26000, 26100);
        send(OP_QUERY, 0, 300, 20);
        // extreme coordinates and radius
        send(OP_WRITE, 0, 8388607, 8388607);
        send(OP_WRITE, 1, -8388608, -8388608);
        send(OP_WRITE, 2, 8388607, -8388608);
        configure(3, 65535);
        send(OP_QUERY, 0, -8388608, 8388607);
        send(OP_QUERY, 0, 8388607, 0);
        configure(3, 0);
        send(OP_QUERY, 0, 0, 0);
        send(OP_QUERY, 0, 8388607, 100);
        // count beyond the memory size is clamped
        configure(127, 300);
        send(OP_QUERY, 0, 0, 0);
        configure(64, 1000);
        send(OP_QUERY, 0, 20000, -3000);

        for (int ph = 0; ph < 3; ph++) begin
            gap_pct   = (ph == 0) ? 10 : (ph == 1) ? 46 : 0;
            stall_pct = (ph == 0) ? 46 : (ph == 1) ? 10 : 0;
            for (int s = 0; s < 5; s++) begin
                sel = $urandom_range(9);
                if (sel == 0) count = 64;
                else if (sel == 1) count = ($urandom_range(1) == 1) ? $urandom_range(1) : 127;
                else count = $urandom_range(3, 10);
                sel = $urandom_range(9);
                if (sel == 0) rad = 0;
                else if (sel == 1) rad = 65535;
                else if (sel == 2) rad = $urandom_range(65535);
                else rad = $urandom_range(1500);
                configure(count, rad);
                if (cur_count >= 3 && cur_count <= 10)
                    write_polygon(cur_count, $urandom_range(8000, 200000));
                if (ph == 2 && s == 0) pressure_go = 1'b1;
                for (int k = 0; k < 12; k++) begin
                    sel = $urandom_range(9);
                    if (sel < 8 && cur_count >= 2) query_near_edge();
                    else if (sel < 9)
                        send(OP_QUERY, 0, $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF));
                    else
                        send(OP_WRITE, $urandom_range(63), $urandom_range(24'hFFFFFF),
                             $urandom_range(24'hFFFFFF));
                end
            end
        end

        settle();
        repeat (50) @(posedge i_clk);
        $display("covered %0d queries, %0d results, %0d found, over three idle patterns",
                 queries, result_count, found_count);
        $display("register settings included counts 0, 1, 2, 64, 127 and radius 0 and 65535");
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/cpe_pkg.sv
hw/rtl/cpe_in_if.sv
hw/rtl/cpe_out_if.sv
hw/rtl/cpe_dp.sv
hw/rtl/cpe_ctrl.sv
hw/rtl/closest_point_on_polygon_edge.sv
bench/cpe_checker.sv
bench/tb_top.sv
